// ----- design/afr_pkg.sv -----
// ---------------------------------------------------------------------------
// afr_pkg - shared types and constants for the metallic Fresnel block
// Transaction payload structs, the I/O fixed-point format and the constants
// that set the facing reflectance clamp.
// ---------------------------------------------------------------------------
package afr_pkg;

   localparam int IO_W    = 17;   // port field width
   localparam int IO_FRAC = 16;   // fraction bits on the ports
   localparam int CONV_W  = 25;   // scratch width for format conversion

   // Facing reflectance clamp: round(0.99 * ONE)
   localparam int R_NUM  = 99;
   localparam int R_DEN  = 100;
   localparam int R_HALF = 50;

   typedef logic [IO_W-1:0] io_type;

   typedef struct packed {
      io_type base_red;
      io_type base_green;
      io_type base_blue;
      io_type edge_red;
      io_type edge_green;
      io_type edge_blue;
      io_type cos_view;
   } req_type;

   typedef struct packed {
      io_type refl_red;
      io_type refl_green;
      io_type refl_blue;
   } rsp_type;

endpackage

// ----- design/afr_div.sv -----
// ---------------------------------------------------------------------------
// afr_div - pipelined fixed-point divider
// Computes floor(num * 2^FB / den) by restoring division, one quotient bit
// per registered stage. A side payload travels alongside.
// ---------------------------------------------------------------------------
module afr_div #(
   parameter int NW = 17,
   parameter int DW = 17,
   parameter int QW = 17,
   parameter int FB = 16,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [PW-1:0] out_pay
);

   localparam int EW = DW + QW;

   logic [NW+FB-1:0] dividend;
   logic [EW-1:0]    ext;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [PW-1:0] pay_ff [QW];
   logic [QW-1:0] vld_ff;

   // quotient fits QW bits, so the upper part starts below the divisor
   assign dividend = {in_num, {FB{1'b0}}};
   assign ext      = EW'(dividend);

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [DW-1:0] den_prev;
      logic [PW-1:0] pay_prev;
      logic          vld_prev;
      logic [DW:0]   cat;
      logic [DW:0]   sub;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] low_in;

      if (k == 0) begin : g_first
         assign rem_prev = ext[EW-1:QW];
         assign low_prev = ext[QW-1:0];
         assign den_prev = in_den;
         assign pay_prev = in_pay;
         assign vld_prev = in_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign pay_prev = pay_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      assign cat    = {rem_prev, low_prev[QW-1]};
      assign sub    = cat - {1'b0, den_prev};
      assign take   = (cat >= {1'b0, den_prev});
      assign rem_in = take ? sub[DW-1:0] : cat[DW-1:0];
      assign low_in = {low_prev[QW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k] <= rem_in;
         low_ff[k] <= low_in;
         den_ff[k] <= den_prev;
         pay_ff[k] <= pay_prev;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = low_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule

// ----- design/afr_sqrt.sv -----
// ---------------------------------------------------------------------------
// afr_sqrt - pipelined integer square root
// floor(sqrt(rad)) for a 2*FB-bit radicand, one root bit per stage.
// A side payload travels alongside.
// ---------------------------------------------------------------------------
module afr_sqrt #(
   parameter int FB = 16,
   parameter int PW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*FB-1:0] in_rad,
   input  logic [PW-1:0]   in_pay,
   output logic            out_valid,
   output logic [FB-1:0]   out_root,
   output logic [PW-1:0]   out_pay
);

   logic [FB+1:0]   rem_ff  [FB];
   logic [FB-1:0]   root_ff [FB];
   logic [2*FB-1:0] rad_ff  [FB];
   logic [PW-1:0]   pay_ff  [FB];
   logic [FB-1:0]   vld_ff;

   for (genvar k = 0; k < FB; k++) begin : g_stage
      logic [FB+1:0]   rem_prev;
      logic [FB-1:0]   root_prev;
      logic [2*FB-1:0] rad_prev;
      logic [PW-1:0]   pay_prev;
      logic            vld_prev;
      logic [FB+1:0]   cat;
      logic [FB+1:0]   trial;
      logic            take;
      logic [FB+1:0]   rem_in;
      logic [FB-1:0]   root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign pay_prev  = in_pay;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign pay_prev  = pay_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // bring down the next two radicand bits
      assign cat     = {rem_prev[FB-1:0], rad_prev[2*FB-1:2*FB-2]};
      assign trial   = {root_prev, 2'b01};
      assign take    = (cat >= trial);
      assign rem_in  = take ? (cat - trial) : cat;
      assign root_in = {root_prev[FB-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= {rad_prev[2*FB-3:0], 2'b00};
         pay_ff[k]  <= pay_prev;
      end
   end

   assign out_valid = vld_ff[FB-1];
   assign out_root  = root_ff[FB-1];
   assign out_pay   = pay_ff[FB-1];

endmodule

// ----- design/afr_chan.sv -----
// ---------------------------------------------------------------------------
// afr_chan - one color channel of the metallic Fresnel pipeline
// Clamp, index from reflectance and tint, k squared, then the averaged
// s and p conductor terms.
// ---------------------------------------------------------------------------
module afr_chan #(
   parameter int FB = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  afr_pkg::io_type         in_base,
   input  afr_pkg::io_type         in_edge,
   input  logic [FB:0]             in_cos,
   output logic                    out_valid,
   output afr_pkg::io_type         out_refl
);

   localparam int W1   = FB + 1;
   localparam int NNW  = FB + 9;    // n, nmax
   localparam int SQW  = FB + 18;   // squares of n
   localparam int K2W  = FB + 25;
   localparam int AW   = FB + 26;
   localparam int TW   = FB + 28;
   localparam int CW   = afr_pkg::CONV_W;
   localparam int UP   = (FB >= afr_pkg::IO_FRAC) ? FB - afr_pkg::IO_FRAC : 0;
   localparam int DOWN = (FB < afr_pkg::IO_FRAC) ? afr_pkg::IO_FRAC - FB : 0;

   localparam logic [FB:0] ONE     = {1'b1, {FB{1'b0}}};
   localparam logic [FB:0] R_LIMIT =
      W1'(((afr_pkg::R_NUM << FB) + afr_pkg::R_HALF) / afr_pkg::R_DEN);

   // ---- stage A: format, clamp, complements
   logic [CW-1:0] base_w, edge_w;
   logic [FB:0]   r_raw, g_raw, r_in, g_in;
   logic [FB:0]   r_ff, g_ff, gi_ff, ri_ff, c_ff;
   logic          a_vld_ff;

   assign base_w = (CW'(in_base) << UP) >> DOWN;
   assign edge_w = (CW'(in_edge) << UP) >> DOWN;
   assign r_raw  = base_w[FB:0];
   assign g_raw  = edge_w[FB:0];
   assign r_in   = (r_raw > R_LIMIT) ? R_LIMIT : r_raw;
   assign g_in   = (g_raw > ONE) ? ONE : g_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
      end
      r_ff  <= r_in;
      g_ff  <= g_in;
      gi_ff <= ONE - g_in;
      ri_ff <= ONE - r_in;
      c_ff  <= in_cos;
   end

   // ---- square root of r
   logic          s_vld;
   logic [FB-1:0] s_root;
   logic [FB:0]   s_r, s_g, s_gi, s_ri, s_c;

   afr_sqrt #(.FB(FB), .PW(5*W1)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .in_rad    ({r_ff[FB-1:0], {FB{1'b0}}}),
      .in_pay    ({r_ff, g_ff, gi_ff, ri_ff, c_ff}),
      .out_valid (s_vld),
      .out_root  (s_root),
      .out_pay   ({s_r, s_g, s_gi, s_ri, s_c})
   );

   // ---- nmin and nmax side by side, same latency
   logic           m_vld;
   logic [NNW-1:0] nmin_q, nmax_q;
   logic [FB:0]    m_r, m_g, m_gi, m_ri, m_c;

   afr_div #(.NW(W1), .DW(W1), .QW(NNW), .FB(FB), .PW(5*W1)) u_div_nmin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_vld),
      .in_num    (s_ri),
      .in_den    (ONE + s_r),
      .in_pay    ({s_r, s_g, s_gi, s_ri, s_c}),
      .out_valid (m_vld),
      .out_quo   (nmin_q),
      .out_pay   ({m_r, m_g, m_gi, m_ri, m_c})
   );

   afr_div #(.NW(W1), .DW(W1), .QW(NNW), .FB(FB), .PW(1)) u_div_nmax (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_vld),
      .in_num    (ONE + W1'(s_root)),
      .in_den    (ONE - W1'(s_root)),
      .in_pay    (1'b0),
      .out_valid (),
      .out_quo   (nmax_q),
      .out_pay   ()
   );

   // ---- C1: blend products
   logic [2*FB+9:0] p1_full, p2_full;
   logic [NNW-1:0]  p1_ff, p2_ff;
   logic [FB:0]     c1_r_ff, c1_ri_ff, c1_c_ff;
   logic            c1_vld_ff;

   assign p1_full = (2*FB+10)'(nmin_q) * (2*FB+10)'(m_g);
   assign p2_full = (2*FB+10)'(nmax_q) * (2*FB+10)'(m_gi);

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
      end else begin
         c1_vld_ff <= m_vld;
      end
      p1_ff    <= p1_full[FB+NNW-1:FB];
      p2_ff    <= p2_full[FB+NNW-1:FB];
      c1_r_ff  <= m_r;
      c1_ri_ff <= m_ri;
      c1_c_ff  <= m_c;
   end

   // ---- C2: n, n+1, |n-1|
   logic [NNW-1:0] n_in;
   logic [NNW-1:0] n_ff, np1_ff, nm1_ff;
   logic [FB:0]    c2_r_ff, c2_ri_ff, c2_c_ff;
   logic           c2_vld_ff;

   assign n_in = p1_ff + p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_vld_ff <= 1'b0;
      end else begin
         c2_vld_ff <= c1_vld_ff;
      end
      n_ff     <= n_in;
      np1_ff   <= n_in + NNW'(ONE);
      nm1_ff   <= (n_in >= NNW'(ONE)) ? n_in - NNW'(ONE) : NNW'(ONE) - n_in;
      c2_r_ff  <= c1_r_ff;
      c2_ri_ff <= c1_ri_ff;
      c2_c_ff  <= c1_c_ff;
   end

   // ---- C3: squares and view terms
   logic [2*NNW-1:0]   sq_full, pb_full, nn_full;
   logic [NNW+W1-1:0]  nc_full;
   logic [2*W1-1:0]    cc_full;
   logic [SQW-1:0]     sq_ff, c3_pb_ff, c3_nn_ff;
   logic [NNW-1:0]     c3_nc_ff;
   logic [FB:0]        c3_cc_ff, c3_r_ff, c3_ri_ff;
   logic               c3_vld_ff;

   assign sq_full = (2*NNW)'(np1_ff) * (2*NNW)'(np1_ff);
   assign pb_full = (2*NNW)'(nm1_ff) * (2*NNW)'(nm1_ff);
   assign nn_full = (2*NNW)'(n_ff) * (2*NNW)'(n_ff);
   assign nc_full = (NNW+W1)'(n_ff) * (NNW+W1)'(c2_c_ff);
   assign cc_full = (2*W1)'(c2_c_ff) * (2*W1)'(c2_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_vld_ff <= 1'b0;
      end else begin
         c3_vld_ff <= c2_vld_ff;
      end
      sq_ff    <= sq_full[FB+SQW-1:FB];
      c3_pb_ff <= pb_full[FB+SQW-1:FB];
      c3_nn_ff <= nn_full[FB+SQW-1:FB];
      c3_nc_ff <= nc_full[FB+NNW-1:FB];
      c3_cc_ff <= cc_full[FB+W1-1:FB];
      c3_r_ff  <= c2_r_ff;
      c3_ri_ff <= c2_ri_ff;
   end

   // ---- C4: (n+1)^2 * r
   logic [SQW+W1-1:0] pa_full;
   logic [SQW-1:0]    pa_ff, c4_pb_ff, c4_nn_ff;
   logic [NNW-1:0]    c4_nc_ff;
   logic [FB:0]       c4_cc_ff, c4_ri_ff;
   logic              c4_vld_ff;

   assign pa_full = (SQW+W1)'(sq_ff) * (SQW+W1)'(c3_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_vld_ff <= 1'b0;
      end else begin
         c4_vld_ff <= c3_vld_ff;
      end
      pa_ff    <= pa_full[FB+SQW-1:FB];
      c4_pb_ff <= c3_pb_ff;
      c4_nn_ff <= c3_nn_ff;
      c4_nc_ff <= c3_nc_ff;
      c4_cc_ff <= c3_cc_ff;
      c4_ri_ff <= c3_ri_ff;
   end

   // ---- C5: k2 numerator, floored at zero
   logic [SQW-1:0] diff_ff, c5_nn_ff;
   logic [NNW-1:0] c5_nc_ff;
   logic [FB:0]    c5_cc_ff, c5_ri_ff;
   logic           c5_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c5_vld_ff <= 1'b0;
      end else begin
         c5_vld_ff <= c4_vld_ff;
      end
      diff_ff  <= (pa_ff > c4_pb_ff) ? pa_ff - c4_pb_ff : '0;
      c5_nn_ff <= c4_nn_ff;
      c5_nc_ff <= c4_nc_ff;
      c5_cc_ff <= c4_cc_ff;
      c5_ri_ff <= c4_ri_ff;
   end

   // ---- k2 = diff / (1 - r)
   logic           k_vld;
   logic [K2W-1:0] k2_q;
   logic [SQW-1:0] k_nn;
   logic [NNW-1:0] k_nc;
   logic [FB:0]    k_cc;

   afr_div #(.NW(SQW), .DW(W1), .QW(K2W), .FB(FB), .PW(SQW+NNW+W1)) u_div_k2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c5_vld_ff),
      .in_num    (diff_ff),
      .in_den    (c5_ri_ff),
      .in_pay    ({c5_nn_ff, c5_nc_ff, c5_cc_ff}),
      .out_valid (k_vld),
      .out_quo   (k2_q),
      .out_pay   ({k_nn, k_nc, k_cc})
   );

   // ---- D1: a = n^2 + k2, 2nc
   logic [AW-1:0]  a_ff;
   logic [NNW:0]   d1_nc2_ff;
   logic [FB:0]    d1_cc_ff;
   logic           d1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
      end else begin
         d1_vld_ff <= k_vld;
      end
      a_ff      <= AW'(k_nn) + AW'(k2_q);
      d1_nc2_ff <= {k_nc, 1'b0};
      d1_cc_ff  <= k_cc;
   end

   // ---- D2: a + c^2, a * c^2
   logic [AW+W1-1:0] ac_full;
   logic [TW-1:0]    d2_ts_ff;
   logic [AW-1:0]    ac2_ff;
   logic [NNW:0]     d2_nc2_ff;
   logic             d2_vld_ff;

   assign ac_full = (AW+W1)'(a_ff) * (AW+W1)'(d1_cc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_vld_ff <= 1'b0;
      end else begin
         d2_vld_ff <= d1_vld_ff;
      end
      d2_ts_ff  <= TW'(a_ff) + TW'(d1_cc_ff);
      ac2_ff    <= ac_full[FB+AW-1:FB];
      d2_nc2_ff <= d1_nc2_ff;
   end

   // ---- D3: a*c^2 + 1
   logic [TW-1:0] d3_ts_ff, d3_tp_ff;
   logic [TW-1:0] d3_nc2_ff;
   logic          d3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d3_vld_ff <= 1'b0;
      end else begin
         d3_vld_ff <= d2_vld_ff;
      end
      d3_ts_ff  <= d2_ts_ff;
      d3_tp_ff  <= TW'(ac2_ff) + TW'(ONE);
      d3_nc2_ff <= TW'(d2_nc2_ff);
   end

   // ---- D4: numerators floored at zero, denominators
   logic [TW-1:0] num_s_ff, den_s_ff, num_p_ff, den_p_ff;
   logic          d4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d4_vld_ff <= 1'b0;
      end else begin
         d4_vld_ff <= d3_vld_ff;
      end
      num_s_ff <= (d3_ts_ff > d3_nc2_ff) ? d3_ts_ff - d3_nc2_ff : '0;
      den_s_ff <= d3_ts_ff + d3_nc2_ff;
      num_p_ff <= (d3_tp_ff > d3_nc2_ff) ? d3_tp_ff - d3_nc2_ff : '0;
      den_p_ff <= d3_tp_ff + d3_nc2_ff;
   end

   // ---- rs and rp side by side
   logic        q_vld;
   logic [FB:0] rs_q, rp_q;

   afr_div #(.NW(TW), .DW(TW), .QW(W1), .FB(FB), .PW(1)) u_div_rs (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d4_vld_ff),
      .in_num    (num_s_ff),
      .in_den    (den_s_ff),
      .in_pay    (1'b0),
      .out_valid (q_vld),
      .out_quo   (rs_q),
      .out_pay   ()
   );

   afr_div #(.NW(TW), .DW(TW), .QW(W1), .FB(FB), .PW(1)) u_div_rp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d4_vld_ff),
      .in_num    (num_p_ff),
      .in_den    (den_p_ff),
      .in_pay    (1'b0),
      .out_valid (),
      .out_quo   (rp_q),
      .out_pay   ()
   );

   // ---- E: average, saturate, back to port format
   logic [FB+1:0]   sum;
   logic [FB:0]     avg, sat;
   logic [CW-1:0]   out_w;
   afr_pkg::io_type refl_ff;
   logic            out_vld_ff;

   assign sum   = (FB+2)'(rs_q) + (FB+2)'(rp_q);
   assign avg   = sum[FB+1:1];
   assign sat   = (avg > ONE) ? ONE : avg;
   assign out_w = (CW'(sat) << DOWN) >> UP;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= q_vld;
      end
      refl_ff <= out_w[afr_pkg::IO_W-1:0];
   end

   assign out_valid = out_vld_ff;
   assign out_refl  = refl_ff;

endmodule

// ----- design/artist_metal_fresnel_rgb_top.sv -----
// ---------------------------------------------------------------------------
// artist_metal_fresnel_rgb_top - artist-friendly metallic Fresnel, RGB
// Turns facing reflectance and edge tint per color into a conductor index
// and returns the averaged s/p Fresnel reflectance at the given view cosine.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                       Direction  Handshake
//  --------  --------------------------  ---------  -----------------------
//  request   start, busy, req_payload    in         start & !busy
//  response  rsp_strobe, rsp_payload     out        one-cycle strobe
//
//  One transaction is taken per clock while busy is low. The latency
//  is set by the chain of bit-per-stage units: the square root, the
//  index division, the k squared division and the final Fresnel
//  quotients. Reset clears every valid bit in the pipeline and sets
//  busy; busy clears once reset is released and stays low from then on.
//  The receiver cannot stall, so the pipeline advances every cycle.
//
module artist_metal_fresnel_rgb_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  afr_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output afr_pkg::rsp_type rsp_payload
);

   localparam int FB   = FRAC_BITS;
   localparam int CW   = afr_pkg::CONV_W;
   localparam int UP   = (FB >= afr_pkg::IO_FRAC) ? FB - afr_pkg::IO_FRAC : 0;
   localparam int DOWN = (FB < afr_pkg::IO_FRAC) ? afr_pkg::IO_FRAC - FB : 0;

   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   logic          busy_ff;
   logic          take;
   logic [CW-1:0] cos_w;
   logic [FB:0]   cos_raw;
   logic [FB:0]   cos_sat;

   // Busy is set by reset and cleared by the first clock without reset; requests are then accepted every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign take = start & ~busy_ff;

   // The view cosine is common to all three colors: convert and saturate
   // it once, here, before it enters the channels.
   assign cos_w   = (CW'(req_payload.cos_view) << UP) >> DOWN;
   assign cos_raw = cos_w[FB:0];
   assign cos_sat = (cos_raw > ONE) ? ONE : cos_raw;

   // Three identical channels run in lock step, so the red channel's
   // valid marks the result for all three.
   afr_chan #(.FB(FB)) u_chan_red (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_base   (req_payload.base_red),
      .in_edge   (req_payload.edge_red),
      .in_cos    (cos_sat),
      .out_valid (rsp_strobe),
      .out_refl  (rsp_payload.refl_red)
   );

   afr_chan #(.FB(FB)) u_chan_green (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_base   (req_payload.base_green),
      .in_edge   (req_payload.edge_green),
      .in_cos    (cos_sat),
      .out_valid (),
      .out_refl  (rsp_payload.refl_green)
   );

   afr_chan #(.FB(FB)) u_chan_blue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_base   (req_payload.base_blue),
      .in_edge   (req_payload.edge_blue),
      .in_cos    (cos_sat),
      .out_valid (),
      .out_refl  (rsp_payload.refl_blue)
   );

endmodule

// ----- bench/tb_artist_metal_fresnel_rgb_top.sv -----
// ---------------------------------------------------------------------------
// tb_artist_metal_fresnel_rgb_top - self-checking bench for the metallic Fresnel
// Drives request transactions through a directed table and then random
// traffic, predicts each RGB reflectance in fixed point and compares every
// strobed response against the oldest pending prediction.
// ---------------------------------------------------------------------------
module tb_artist_metal_fresnel_rgb_top;

   localparam int FB       = 16;
   localparam int LATENCY  = 4*FB + 46;
   localparam int WD_LIMIT = 4000;
   localparam int N_RANDOM = 1400;
   localparam logic [63:0] ONE = 64'd1 << FB;
   localparam logic [63:0] R_MAX = ((64'd99 << FB) + 64'd50) / 64'd100;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   afr_pkg::req_type req_payload = '0;
   logic             rsp_strobe;
   afr_pkg::rsp_type rsp_payload;

   afr_pkg::rsp_type refl_queue[$];
   int               fail_count = 0;
   int               idle_cycles = 0;
   int               send_idle_pct = 34;

   artist_metal_fresnel_rgb_top #(.FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // ---- fixed-point helpers: floor product, floor quotient, floor sqrt ----
   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return p[FB +: 64];
   endfunction

   function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
      logic [127:0] q;
      if (b == 0) return '1;
      q = ({64'd0, a} << FB) / {64'd0, b};
      return q[63:0];
   endfunction

   function automatic logic [63:0] qsqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // One color channel of the conductor Fresnel average, 16 fraction bits out.
   function automatic afr_pkg::io_type fresnel_channel(afr_pkg::io_type base,
                                                       afr_pkg::io_type edge_tint,
                                                       logic [63:0] c);
      logic [63:0] r, g, s, nmin, nmax, n, np1, nm1, pa, pb, k2, a, nc2, c2;
      logic [63:0] t, num, den, rs, rp, res;
      r = base;
      g = edge_tint;
      if (r > R_MAX) r = R_MAX;   // clamp facing reflectance to 0.99
      if (g > ONE) g = ONE;       // saturate edge tint to 1.0
      nmin = qdiv(ONE - r, ONE + r);
      s    = qsqrt(r << FB);
      nmax = qdiv(ONE + s, ONE - s);
      n    = qmul(nmin, g) + qmul(nmax, ONE - g);
      np1  = n + ONE;
      nm1  = (n >= ONE) ? n - ONE : ONE - n;
      pa   = qmul(qmul(np1, np1), r);
      pb   = qmul(nm1, nm1);
      k2   = qdiv((pa > pb) ? pa - pb : 0, ONE - r);
      a    = qmul(n, n) + k2;
      nc2  = qmul(n, c) << 1;
      c2   = qmul(c, c);
      t    = a + c2;
      num  = (t > nc2) ? t - nc2 : 0;
      den  = t + nc2;
      rs   = (den == 0) ? ONE : qdiv(num, den);
      t    = qmul(a, c2) + ONE;
      num  = (t > nc2) ? t - nc2 : 0;
      den  = t + nc2;
      rp   = qdiv(num, den);
      res  = (rs + rp) >> 1;
      if (res > ONE) res = ONE;
      return res[afr_pkg::IO_W-1:0];
   endfunction

   function automatic afr_pkg::rsp_type predict_reflectance(afr_pkg::req_type rq);
      afr_pkg::rsp_type o;
      logic [63:0]      c;
      c = rq.cos_view;
      if (c > ONE) c = ONE;
      o.refl_red   = fresnel_channel(rq.base_red,   rq.edge_red,   c);
      o.refl_green = fresnel_channel(rq.base_green, rq.edge_green, c);
      o.refl_blue  = fresnel_channel(rq.base_blue,  rq.edge_blue,  c);
      return o;
   endfunction

   task automatic report_mismatch(string what, afr_pkg::io_type got,
                                  afr_pkg::io_type want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // ---- response checker: compare every strobe with the oldest prediction ----
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (refl_queue.size() == 0) begin
            $display("UNEXPECTED response %h at %0t", rsp_payload, $realtime);
            fail_count++;
         end else begin
            afr_pkg::rsp_type want;
            want = refl_queue.pop_front();
            if (rsp_payload.refl_red !== want.refl_red)
               report_mismatch("red", rsp_payload.refl_red, want.refl_red);
            if (rsp_payload.refl_green !== want.refl_green)
               report_mismatch("green", rsp_payload.refl_green, want.refl_green);
            if (rsp_payload.refl_blue !== want.refl_blue)
               report_mismatch("blue", rsp_payload.refl_blue, want.refl_blue);
         end
      end
   end

   // ---- watchdog: count cycles with no transaction on either side ----
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Hold start and payload until the block takes the transaction.
   // The predictor runs at acceptance, so the queue order matches.
   task automatic send_request(afr_pkg::req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      refl_queue.push_back(predict_reflectance(rq));
   endtask

   // Random field value: mostly in range, with full 17-bit noise and edges mixed in.
   function automatic afr_pkg::io_type rand_field();
      case ($urandom_range(9))
         0:       return afr_pkg::io_type'($urandom);
         1:       return afr_pkg::io_type'(65536);
         2:       return '0;
         3:       return afr_pkg::io_type'($urandom_range(65535, 62000));
         default: return afr_pkg::io_type'($urandom_range(65536));
      endcase
   endfunction

   // Directed table: base, edge and cosine extremes plus the clamp boundaries.
   // Expected values are left to the predictor: none is trivial to read off.
   typedef struct packed {
      afr_pkg::io_type b, e, c;
   } row_type;

   row_type directed_rows[] = '{
      '{17'd0,      17'd0,      17'd0},
      '{17'd0,      17'd65536,  17'd65536},
      '{17'd65536,  17'd0,      17'd65536},
      '{17'd65536,  17'd65536,  17'd0},
      '{17'd64881,  17'd32768,  17'd32768},   // exactly at the 0.99 clamp value
      '{17'd64882,  17'd32768,  17'd32768},   // just above it
      '{17'h1FFFF,  17'h1FFFF,  17'h1FFFF},   // everything saturates
      '{17'd65537,  17'd65537,  17'd65537},
      '{17'd1,      17'd1,      17'd1},
      '{17'd32768,  17'd0,      17'd1},
      '{17'd62000,  17'd65535,  17'd65535},
      '{17'd2621,   17'd60000,  17'd100},
      '{17'd45000,  17'd20000,  17'd50000},
      '{17'h15555,  17'h0AAAA,  17'h15555},   // alternating bit patterns
      '{17'h0AAAA,  17'h15555,  17'h0AAAA}
   };

   initial begin
      afr_pkg::req_type rq;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: same row on all channels, then rotate per channel.
      foreach (directed_rows[i]) begin
         row_type rw;
         rw = directed_rows[i];
         rq = '{rw.b, rw.b, rw.b, rw.e, rw.e, rw.e, rw.c};
         send_request(rq);
         rq = '{rw.b, rw.e, rw.c, rw.c, rw.b, rw.e, rw.b};
         send_request(rq);
      end

      // Random phases: sender idles 34%, then 58%, then never.
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == N_RANDOM/3) send_idle_pct = 58;
         if (k == 2*N_RANDOM/3) send_idle_pct = 0;
         rq = '{rand_field(), rand_field(), rand_field(), rand_field(),
                rand_field(), rand_field(), rand_field()};
         send_request(rq);
      end
      start <= 1'b0;

      // Drain: wait for all predictions, then wait past the pipeline latency before reporting.
      while (refl_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- artist_metal_fresnel_rgb_top.f -----
design/afr_pkg.sv
design/afr_div.sv
design/afr_sqrt.sv
design/afr_chan.sv
design/artist_metal_fresnel_rgb_top.sv
bench/tb_artist_metal_fresnel_rgb_top.sv
